// ----- rtl/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press detect.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    // Event codes carried on the result stream
    typedef enum logic [1:0] {
        EV_DOWN  = 2'd0,
        EV_UP    = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } evt_code_t;

    // Register indexes (byte address is 4 times the index)
    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_ACTIVE     = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    localparam int          ADDR_W         = 4;
    localparam int          TIME_W         = 32;
    localparam int          THRESH_W       = 16;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] LONG_RESET     = 16'd1000;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces BUTTON_COUNT buttons on poll ticks and reports down, up, short
// click and long click events as a stream, in button order.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one poll tick (timestamp and raw pin
// levels). A tick is registered, then evaluated for all buttons at once,
// which updates the debounce state and loads an event buffer of two slots
// per button. The buffer drains one event per cycle into the output register
// whenever that register is empty or its event is taken; a tick causes at
// most two events per button. The next tick waits in the input register and
// is evaluated in the same cycle the last event of the previous tick
// leaves the buffer. m_tlast marks the final event of a tick; a tick with no
// events gives no output. Registers: 0x0 debounce_time, 0x4 long_press_time,
// 0x8 active_levels; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
    parameter int  BUTTON_COUNT = 3,
    localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1,
    localparam int IN_W         = ((32 + BUTTON_COUNT + 7) / 8) * 8,
    localparam int OUT_W        = ((IDX_W + 2 + 7) / 8) * 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Tick stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [IN_W-1:0]            s_tdata,   // time_ms[31:0], pin_levels
    // Event stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_W-1:0]                m_tdata,   // button_index, event_code
    output logic                            m_tlast,   // last_event
    // Configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bdlp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import bdlp_pkg::*;

    localparam int SLOT_N = 2 * BUTTON_COUNT;
    localparam int SEL_W  = IDX_W + 1;

    // Configuration registers
    logic [THRESH_W-1:0]     debounce_reg,  debounce_next;
    logic [THRESH_W-1:0]     long_time_reg, long_time_next;
    logic [BUTTON_COUNT-1:0] active_reg,    active_next;

    // Input register
    logic                    in_valid_reg, in_valid_next;
    logic [TIME_W-1:0]       in_time_reg,  in_time_next;
    logic [BUTTON_COUNT-1:0] in_pins_reg,  in_pins_next;

    // Debounce state per button
    logic [BUTTON_COUNT-1:0] pressed_reg, pressed_next;
    logic [BUTTON_COUNT-1:0] long_reg,    long_next;
    logic [TIME_W-1:0]       stamp_reg  [BUTTON_COUNT];
    logic [TIME_W-1:0]       stamp_next [BUTTON_COUNT];

    // Event buffer: slot 2i holds button i's first event, slot 2i+1 its short click
    logic [SLOT_N-1:0]       pend_reg, pend_next;
    evt_code_t               code_reg  [BUTTON_COUNT];
    evt_code_t               code_next [BUTTON_COUNT];

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_btn_reg,   out_btn_next;
    evt_code_t               out_code_reg,  out_code_next;
    logic                    out_last_reg,  out_last_next;

    // Per-button evaluation results
    logic [BUTTON_COUNT-1:0] accept_chg;
    logic [BUTTON_COUNT-1:0] phys;
    logic [BUTTON_COUNT-1:0] ev_a;
    logic [BUTTON_COUNT-1:0] ev_b;
    logic [BUTTON_COUNT-1:0] ev_long;
    logic [SLOT_N-1:0]       new_pend;

    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic                    s_accept;
    logic                    out_free;
    logic                    pop;
    logic                    pop_last;
    logic                    proc;
    logic [SEL_W-1:0]        sel;
    logic [IDX_W-1:0]        sel_btn;
    logic [SLOT_N-1:0]       sel_onehot;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        debounce_next  = debounce_reg;
        long_time_next = long_time_reg;
        active_next    = active_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DEBOUNCE:   debounce_next  = pwdata[THRESH_W-1:0];
                REG_LONG_PRESS: long_time_next = pwdata[THRESH_W-1:0];
                REG_ACTIVE:     active_next    = pwdata[BUTTON_COUNT-1:0];
                default:        ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE:   prdata = 32'(debounce_reg);
            REG_LONG_PRESS: prdata = 32'(long_time_reg);
            REG_ACTIVE:     prdata = 32'(active_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Event buffer read-out: pick the lowest pending slot
    // ------------------------------------------------------------------
    always_comb
    begin
        sel = '0;
        for (int k = SLOT_N - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                sel = SEL_W'(k);
            end
        end
    end

    assign sel_btn    = sel[SEL_W-1:1];
    assign sel_onehot = SLOT_N'(1) << sel;
    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = (pend_reg != '0) && out_free;
    assign pop_last   = (pend_reg & ~sel_onehot) == '0;

    // Evaluate the held tick once the buffer is empty or emptying now
    assign proc     = in_valid_reg && ((pend_reg == '0) || (pop && pop_last));
    assign s_tready = !in_valid_reg || proc;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Per-button debounce and long-press evaluation
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [TIME_W-1:0] elapsed;
        logic              changed;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            elapsed       = in_time_reg - stamp_reg[i];
            phys[i]       = in_pins_reg[i] == active_reg[i];
            changed       = phys[i] != pressed_reg[i];
            accept_chg[i] = changed && (elapsed >= TIME_W'(debounce_reg));
            ev_long[i]    = !changed && pressed_reg[i] && !long_reg[i]
                            && (elapsed >= TIME_W'(long_time_reg));
            ev_a[i]       = accept_chg[i] || ev_long[i];
            ev_b[i]       = accept_chg[i] && !phys[i] && !long_reg[i];
            new_pend[2*i]     = ev_a[i];
            new_pend[2*i + 1] = ev_b[i];
        end
    end

    // Update state and load the buffer when a tick is evaluated
    always_comb
    begin
        pressed_next = pressed_reg;
        long_next    = long_reg;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            stamp_next[i] = stamp_reg[i];
            code_next[i]  = code_reg[i];
            if (proc)
            begin
                if (accept_chg[i])
                begin
                    pressed_next[i] = phys[i];
                    stamp_next[i]   = in_time_reg;
                    code_next[i]    = phys[i] ? EV_DOWN : EV_UP;
                    if (phys[i])
                    begin
                        long_next[i] = 1'b0;
                    end
                end
                else if (ev_long[i])
                begin
                    long_next[i] = 1'b1;
                    code_next[i] = EV_LONG;
                end
            end
        end
    end

    always_comb
    begin
        if (proc)
        begin
            pend_next = new_pend;
        end
        else if (pop)
        begin
            pend_next = pend_reg & ~sel_onehot;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_comb
    begin
        in_time_next  = in_time_reg;
        in_pins_next  = in_pins_reg;
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_time_next  = s_tdata[TIME_W-1:0];
            in_pins_next  = s_tdata[TIME_W +: BUTTON_COUNT];
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_btn_next   = out_btn_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_btn_next   = sel_btn;
            out_code_next  = sel[0] ? EV_SHORT : code_reg[sel_btn];
            out_last_next  = pop_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_code_reg, out_btn_reg});
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            long_time_reg <= LONG_RESET;
            active_reg    <= '0;
            in_valid_reg  <= 1'b0;
            pressed_reg   <= '0;
            long_reg      <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            debounce_reg  <= debounce_next;
            long_time_reg <= long_time_next;
            active_reg    <= active_next;
            in_valid_reg  <= in_valid_next;
            pressed_reg   <= pressed_next;
            long_reg      <= long_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_time_reg  <= in_time_next;
        in_pins_reg  <= in_pins_next;
        out_btn_reg  <= out_btn_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            code_reg[i] <= code_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new tick replaces a held one only in the cycle that one is evaluated
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_valid_reg) |-> proc)
        else $error("held tick overwritten before evaluation");

    // Popping the final event with no new tick leaves the buffer empty
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_last && !proc) |=> (pend_reg == '0))
        else $error("event buffer not empty after final event");

    // A popped event appears on the output next cycle with the right last flag
    a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && (m_tlast == $past(pop_last))))
        else $error("popped event not presented");

    // A pending short click always follows an up event of the same button
    generate
        for (genvar g = 0; g < BUTTON_COUNT; g++)
        begin : g_chk
            a_short_after_up: assert property (@(posedge clk) disable iff (!rst_n)
                pend_reg[2*g + 1] |-> (code_reg[g] == EV_UP))
                else $error("short click pending without an up event");
        end
    endgenerate

endmodule

`default_nettype wire

// ----- dv/tb_button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press
// Self-checking bench for the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
// A short scripted sequence covers the debounce window right after reset,
// timestamp wrap, time running backwards, zero and full-scale thresholds,
// register masking, the unused register slot and a tick giving six events.
// Random phases follow, each under fresh register settings, with buttons
// held, toggled and bounced, some raw noise, bursty ticks and a stalling
// event sink. Every event is checked, field by field and in order, against an
// in-bench predictor of the debounce state or a typed scripted expectation.
// ----------------------------------------------------------------------------

module tb_button_debounce_long_press;

    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    localparam int NBTN          = 3;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_MAX     = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;
    localparam int TICKS_PHASE   = 70;
    localparam int CYCLE_LIMIT   = 300000;

    // One expected or observed event
    typedef struct packed {
        logic [1:0] btn;
        evt_code_t  code;
        logic       last;
    } btn_event_t;

    // One line of the scripted sequence: a register write or a poll tick
    typedef struct {
        bit          is_cfg;
        reg_idx_t    ridx;
        logic [31:0] wdata;
        logic [31:0] tms;
        logic [2:0]  pins;
        bit          typed;
        int          n_exp;
        logic [1:0]  exp_btn;
        evt_code_t   exp_code;
    } poll_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // time_ms[31:0], pin_levels[34:32], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // button_index[1:0], event_code[3:2], zero fill
    logic        m_tlast;   // last_event
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and the per-button debounce state
    logic [15:0] cfg_db;
    logic [15:0] cfg_lp;
    logic [2:0]  cfg_act;
    logic        btn_down   [NBTN];
    logic [31:0] btn_chg_ts [NBTN];
    logic        btn_long   [NBTN];

    btn_event_t  pending_events [$];

    // Typed expectation for the request currently offered
    bit          typed_on;
    int          typed_n;
    logic [1:0]  typed_btn;
    evt_code_t   typed_code;

    int          faults;
    int          ticks_seen;
    int          events_seen;
    int          code_seen [4];
    int          settings_used;
    int          cyc;
    bit          hold_req;

    button_debounce_long_press dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle count and run limit
    initial
    begin
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > CYCLE_LIMIT)
            begin
                $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Work out the events of one tick and advance the debounce state
    function automatic void debounce_tick(input logic [31:0] now, input logic [2:0] pins,
                                          input bit queue_it);
        btn_event_t evs [$];
        btn_event_t ev;
        logic       phys;
        logic [31:0] elapsed;
        for (int b = 0; b < NBTN; b++)
        begin
            phys    = (pins[b] == cfg_act[b]);
            elapsed = now - btn_chg_ts[b];
            ev.btn  = 2'(b);
            ev.last = 1'b0;
            if (phys != btn_down[b])
            begin
                if (elapsed >= {16'd0, cfg_db})
                begin
                    btn_down[b]   = phys;
                    btn_chg_ts[b] = now;
                    if (phys)
                    begin
                        btn_long[b] = 1'b0;
                        ev.code = EV_DOWN;
                        evs.push_back(ev);
                    end
                    else
                    begin
                        ev.code = EV_UP;
                        evs.push_back(ev);
                        if (!btn_long[b])
                        begin
                            ev.code = EV_SHORT;
                            evs.push_back(ev);
                        end
                    end
                end
            end
            else if (btn_down[b] && !btn_long[b] && elapsed >= {16'd0, cfg_lp})
            begin
                btn_long[b] = 1'b1;
                ev.code = EV_LONG;
                evs.push_back(ev);
            end
        end
        if (evs.size() > 0)
            evs[evs.size()-1].last = 1'b1;
        if (queue_it)
            foreach (evs[i])
                pending_events.push_back(evs[i]);
    endfunction

    // Record accepted ticks and check accepted events; sample between edges
    always @(negedge clk)
    begin
        btn_event_t want;
        btn_event_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                ticks_seen++;
                debounce_tick(s_tdata[31:0], s_tdata[34:32], !typed_on);
                if (typed_on && typed_n > 0)
                begin
                    want.btn  = typed_btn;
                    want.code = typed_code;
                    want.last = 1'b1;
                    pending_events.push_back(want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got.btn  = m_tdata[1:0];
                got.code = evt_code_t'(m_tdata[3:2]);
                got.last = m_tlast;
                events_seen++;
                code_seen[got.code]++;
                if (pending_events.size() == 0)
                begin
                    faults++;
                    $display("%0t: unexpected event: got btn=%0d code=%s last=%0b", $time,
                             got.btn, got.code.name(), got.last);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.btn !== want.btn || got.code !== want.code
                        || got.last !== want.last)
                    begin
                        faults++;
                        $display({"%0t: event mismatch: expected btn=%0d code=%s last=%0b,",
                                  " got btn=%0d code=%s last=%0b"},
                                 $time, want.btn, want.code.name(), want.last,
                                 got.btn, got.code.name(), got.last);
                    end
                end
            end
        end
    end

    // Event sink: stall in windows of varying pattern, or hold off on request
    initial
    begin
        int win_left;
        int mode;
        int hold_left;
        win_left  = 0;
        mode      = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
                if (hold_left == 0)
                    hold_req = 1'b0;
            end
            else
            begin
                if (win_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    win_left = $urandom_range(16, 80);
                end
                win_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cyc % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic poll_row_t tick_row(input logic [31:0] t, input logic [2:0] p,
                                           input bit typed, input int n,
                                           input logic [1:0] b, input evt_code_t c);
        poll_row_t r;
        r.is_cfg   = 1'b0;
        r.ridx     = REG_NONE;
        r.wdata    = '0;
        r.tms      = t;
        r.pins     = p;
        r.typed    = typed;
        r.n_exp    = n;
        r.exp_btn  = b;
        r.exp_code = c;
        return r;
    endfunction

    function automatic poll_row_t cfg_row(input reg_idx_t idx, input logic [31:0] v);
        poll_row_t r;
        r = tick_row('0, '0, 1'b0, 0, 2'd0, EV_DOWN);
        r.is_cfg = 1'b1;
        r.ridx   = idx;
        r.wdata  = v;
        return r;
    endfunction

    // Offer one tick request and hold it until accepted
    task automatic send_tick(input poll_row_t r);
        typed_on   = r.typed;
        typed_n    = r.n_exp;
        typed_btn  = r.exp_btn;
        typed_code = r.exp_code;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, r.pins, r.tms};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    task automatic idle_gap(input int g);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every outstanding event, then let the block settle
    task automatic drain_events();
        int waited;
        btn_event_t w;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_events.size() != 0)
        begin
            w = pending_events.pop_front();
            faults++;
            $display("%0t: missing event: expected btn=%0d code=%s last=%0b, got nothing",
                     $time, w.btn, w.code.name(), w.last);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, then read all of them back
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        reg_idx_t    ri;
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   cfg_db  = val[15:0];
            REG_LONG_PRESS: cfg_lp  = val[15:0];
            REG_ACTIVE:     cfg_act = val[2:0];
            default:        ;
        endcase
        settings_used++;
        @(posedge clk);
        for (ri = REG_DEBOUNCE; ri != REG_NONE; ri = ri.next())
        begin
            psel  <= 1'b1;
            paddr <= ADDR_W'({ri, 2'b00});
            @(posedge clk);
            penable <= 1'b1;
            @(negedge clk);
            case (ri)
                REG_DEBOUNCE:   want = {16'd0, cfg_db};
                REG_LONG_PRESS: want = {16'd0, cfg_lp};
                default:        want = {29'd0, cfg_act};
            endcase
            if (prdata !== want)
            begin
                faults++;
                $display("%0t: register %s readback: expected 0x%08h, got 0x%08h",
                         $time, ri.name(), want, prdata);
            end
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        poll_row_t   script [$];
        poll_row_t   row;
        logic [31:0] now;
        logic [2:0]  intent;
        logic [2:0]  pins;
        logic [15:0] db;
        logic [15:0] lp;
        logic [2:0]  act;
        int          step_max;
        int          burst_left;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_req  = 1'b0;
        typed_on  = 1'b0;
        faults    = 0;
        ticks_seen    = 0;
        events_seen   = 0;
        settings_used = 0;
        foreach (code_seen[i])
            code_seen[i] = 0;
        cfg_db  = DEBOUNCE_RESET;
        cfg_lp  = LONG_RESET;
        cfg_act = 3'd0;
        for (int b = 0; b < NBTN; b++)
        begin
            btn_down[b]   = 1'b0;
            btn_chg_ts[b] = '0;
            btn_long[b]   = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted part, reset settings first (pressed means pin low)
        script.push_back(tick_row(32'd0,          3'b111, 1, 0, 2'd0, EV_DOWN));
        // inside the debounce window right after reset
        script.push_back(tick_row(32'd5,          3'b110, 1, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd20,         3'b110, 1, 1, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd30,         3'b111, 1, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd40,         3'b111, 0, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd100,        3'b000, 0, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd1100,       3'b000, 0, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd1200,       3'b111, 0, 0, 2'd0, EV_DOWN));
        // timestamp wrap
        script.push_back(tick_row(32'hFFFF_FFF0,  3'b011, 1, 1, 2'd2, EV_DOWN));
        script.push_back(tick_row(32'hFFFF_FFFF,  3'b111, 1, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd4,          3'b111, 0, 0, 2'd0, EV_DOWN));
        // time running backwards counts as elapsed
        script.push_back(tick_row(32'd0,          3'b101, 1, 1, 2'd1, EV_DOWN));
        script.push_back(tick_row(32'd50,         3'b000, 0, 0, 2'd0, EV_DOWN));
        // all three released with short clicks: six events
        script.push_back(tick_row(32'd100,        3'b111, 0, 0, 2'd0, EV_DOWN));
        // zero thresholds, junk in unused register bits
        script.push_back(cfg_row(REG_DEBOUNCE,    32'hABCD_0000));
        script.push_back(cfg_row(REG_LONG_PRESS,  32'h1234_0000));
        script.push_back(cfg_row(REG_ACTIVE,      32'hFFFF_FFFA));
        script.push_back(tick_row(32'd100,        3'b010, 0, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd100,        3'b010, 0, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd101,        3'b101, 0, 0, 2'd0, EV_DOWN));
        // slot past the register list, then full-scale thresholds
        script.push_back(cfg_row(REG_NONE,        32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_DEBOUNCE,    32'h0000_FFFF));
        script.push_back(cfg_row(REG_LONG_PRESS,  32'h0000_FFFF));
        script.push_back(cfg_row(REG_ACTIVE,      32'h0000_0007));
        script.push_back(tick_row(32'd200,        3'b001, 1, 0, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd65636,      3'b001, 1, 1, 2'd0, EV_DOWN));
        script.push_back(tick_row(32'd131171,     3'b001, 1, 1, 2'd0, EV_LONG));
        script.push_back(tick_row(32'd196706,     3'b000, 1, 1, 2'd0, EV_UP));

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_events();
                reg_write(script[i].ridx, script[i].wdata);
            end
            else
            begin
                send_tick(script[i]);
                idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
            end
        end

        // Random phases, each under its own settings
        now        = 32'd196706;
        intent     = 3'b000;
        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_events();
            case (ph)
                0:
                begin
                    db  = 16'd0;
                    lp  = 16'd0;
                    act = 3'($urandom_range(0, 7));
                end
                1:
                begin
                    db  = 16'hFFFF;
                    lp  = 16'hFFFF;
                    act = 3'b111;
                end
                default:
                begin
                    db  = 16'($urandom_range(0, 60));
                    lp  = 16'($urandom_range(20, 400));
                    act = 3'($urandom_range(0, 7));
                end
            endcase
            reg_write(REG_DEBOUNCE,   ($urandom() & 32'hFFFF_0000) | {16'd0, db});
            reg_write(REG_LONG_PRESS, ($urandom() & 32'hFFFF_0000) | {16'd0, lp});
            reg_write(REG_ACTIVE,     ($urandom() & 32'hFFFF_FFF8) | {29'd0, act});
            step_max = db / 2 + lp / 4 + 15;
            if ($urandom_range(0, 1))
                now = $urandom();

            for (int k = 0; k < TICKS_PHASE; k++)
            begin
                // hold the sink off while ticks keep coming, so the block backs up
                if (ph == 0 && k == 8)
                    hold_req = 1'b1;
                if ($urandom_range(0, 99) < 3)
                    now = $urandom();
                else
                    now = now + 32'($urandom_range(0, step_max));
                // mostly steady presses with toggles and bounce, some raw noise
                if ($urandom_range(0, 99) < 5)
                    pins = 3'($urandom_range(0, 7));
                else
                    for (int b = 0; b < NBTN; b++)
                    begin
                        if ($urandom_range(0, 99) < 12)
                            intent[b] = ~intent[b];
                        pins[b] = intent[b] ^ ($urandom_range(0, 99) < 8);
                    end
                row = tick_row(now, pins, 1'b0, 0, 2'd0, EV_DOWN);
                send_tick(row);
                if (burst_left > 0)
                    burst_left--;
                if (hold_req)
                    idle_gap(0);
                else if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
                end
            end
        end

        drain_events();

        $display("Covered %0d ticks and %0d events over %0d register writes", ticks_seen,
                 events_seen, settings_used);
        $display("Events by kind: down %0d, up %0d, short %0d, long %0d; faults %0d",
                 code_seen[EV_DOWN], code_seen[EV_UP], code_seen[EV_SHORT],
                 code_seen[EV_LONG], faults);
        if (faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
